// ===== rtl/modular_linear_congruence_solver_assert.svh =====
// Assertion macros shared by the solver RTL.
`ifndef MODULAR_LINEAR_CONGRUENCE_SOLVER_ASSERT_SVH
`define MODULAR_LINEAR_CONGRUENCE_SOLVER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MLCS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MLCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mlcs_pkg.sv =====
`default_nettype none

package mlcs_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int VAL_W      = WORD_WIDTH;
  localparam int RES_W      = WORD_WIDTH - 1;
  localparam int SHIFT_W    = $clog2(WORD_WIDTH);
  localparam int STATUS_W   = 2;
  localparam int IN_W       = 96;
  localparam int OUT_W      = 40;
  localparam int OUT_PAD_W  = OUT_W - RES_W - STATUS_W;

  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_COPRIME = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_MODULUS = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_SUB,
    ST_ACC,
    ST_FIXB,
    ST_UPDATE,
    ST_CHECK,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/modular_linear_congruence_solver.sv =====
// One transaction is in flight at a time. One shared comparator-subtractor does the division
// work, and one modular adder accumulates the product of quotient and current right side.
// Reset (rst, synchronous, active high) returns the sequencer to idle and drops tvalid.
`default_nettype none
`include "modular_linear_congruence_solver_assert.svh"

module modular_linear_congruence_solver (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // coefficient [31:0], right_side [63:32], modulus [94:64], zero [95]
  input  wire logic [mlcs_pkg::IN_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // solution [30:0], status [32:31], zero [39:33]
  output logic [mlcs_pkg::OUT_W-1:0]         m_tdata
);

  localparam int VW = mlcs_pkg::VAL_W;
  localparam int RW = mlcs_pkg::RES_W;
  localparam int KW = mlcs_pkg::SHIFT_W;

  mlcs_pkg::state_t state, state_next;

  logic [RW-1:0]    mod_q;
  logic [VW-1:0]    a_mag;
  logic             b_flip;
  logic             reducing;
  logic [VW-1:0]    rem;
  logic [VW-1:0]    dvs;
  logic [KW-1:0]    k;
  logic             last;
  logic [RW-1:0]    acc;
  logic [VW-1:0]    pv;
  logic [RW-1:0]    pr;
  logic [VW-1:0]    cv;
  logic [RW-1:0]    cr;
  logic [RW-1:0]    solution;
  logic [mlcs_pkg::STATUS_W-1:0] status;

  logic [VW-1:0]    in_coef;
  logic [VW-1:0]    in_rhs;
  logic [RW-1:0]    in_mod;

  logic [VW:0]      cmp_lhs;
  logic [VW:0]      cmp_rhs;
  logic             cmp_ge;
  logic [VW:0]      cmp_diff;

  logic [VW-1:0]    madd_sum;
  logic [VW-1:0]    madd_red;

  logic [RW-1:0]    b_red;
  logic [RW-1:0]    right;

  assign in_coef = s_tdata[31:0];
  assign in_rhs  = s_tdata[63:32];
  assign in_mod  = s_tdata[94:64];

  // Shared comparator: against the doubled divisor while aligning, the divisor otherwise.
  assign cmp_lhs  = {1'b0, rem};
  assign cmp_rhs  = (state == mlcs_pkg::ST_ALIGN) ? {dvs, 1'b0} : {1'b0, dvs};
  assign cmp_ge   = (cmp_lhs >= cmp_rhs);
  assign cmp_diff = cmp_lhs - cmp_rhs;

  // Shared modular adder: doubles the product accumulator, or adds the current right side.
  assign madd_sum = {1'b0, acc} +
                    ((state == mlcs_pkg::ST_ACC) ? {1'b0, cr} : {1'b0, acc});
  assign madd_red = (madd_sum >= {1'b0, mod_q}) ? (madd_sum - {1'b0, mod_q}) : madd_sum;

  assign b_red = (b_flip && (rem[RW-1:0] != '0)) ? (mod_q - rem[RW-1:0]) : rem[RW-1:0];
  assign right = (pr >= acc) ? (pr - acc) : (pr + (mod_q - acc));

  always_comb begin
    state_next = state;
    unique case (state)
      mlcs_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (in_mod < RW'(2)) ? mlcs_pkg::ST_DONE : mlcs_pkg::ST_ALIGN;
        end
      end
      mlcs_pkg::ST_ALIGN: begin
        state_next = cmp_ge ? mlcs_pkg::ST_ALIGN : mlcs_pkg::ST_SUB;
      end
      mlcs_pkg::ST_SUB: begin
        if (!reducing && cmp_ge) begin
          state_next = mlcs_pkg::ST_ACC;
        end else if (k == '0) begin
          state_next = reducing ? mlcs_pkg::ST_FIXB : mlcs_pkg::ST_UPDATE;
        end
      end
      mlcs_pkg::ST_ACC: begin
        state_next = last ? mlcs_pkg::ST_UPDATE : mlcs_pkg::ST_SUB;
      end
      mlcs_pkg::ST_FIXB: begin
        state_next = (a_mag == '0) ? mlcs_pkg::ST_DONE : mlcs_pkg::ST_CHECK;
      end
      mlcs_pkg::ST_UPDATE: begin
        state_next = (rem == '0) ? mlcs_pkg::ST_DONE : mlcs_pkg::ST_CHECK;
      end
      mlcs_pkg::ST_CHECK: begin
        state_next = (cv == VW'(1)) ? mlcs_pkg::ST_DONE : mlcs_pkg::ST_ALIGN;
      end
      mlcs_pkg::ST_DONE: begin
        if (m_tready) begin
          state_next = mlcs_pkg::ST_IDLE;
        end
      end
      default: state_next = mlcs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == mlcs_pkg::ST_IDLE);
    m_tvalid = (state == mlcs_pkg::ST_DONE);
    m_tdata  = {{mlcs_pkg::OUT_PAD_W{1'b0}}, status, solution};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlcs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      mlcs_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          mod_q    <= in_mod;
          a_mag    <= in_coef[VW-1] ? (VW'(0) - in_coef) : in_coef;
          b_flip   <= in_coef[VW-1] ^ in_rhs[VW-1];
          rem      <= in_rhs[VW-1] ? (VW'(0) - in_rhs) : in_rhs;
          dvs      <= {1'b0, in_mod};
          k        <= '0;
          acc      <= '0;
          reducing <= 1'b1;
          solution <= '0;
          status   <= mlcs_pkg::STATUS_BAD_MODULUS;
        end
      end
      mlcs_pkg::ST_ALIGN: begin
        if (cmp_ge) begin
          dvs <= {dvs[VW-2:0], 1'b0};
          k   <= k + KW'(1);
        end
      end
      mlcs_pkg::ST_SUB: begin
        if (cmp_ge) begin
          rem <= cmp_diff[VW-1:0];
        end
        acc  <= madd_red[RW-1:0];
        last <= (k == '0);
        if (k != '0) begin
          dvs <= {1'b0, dvs[VW-1:1]};
          k   <= k - KW'(1);
        end
      end
      mlcs_pkg::ST_ACC: begin
        acc <= madd_red[RW-1:0];
      end
      mlcs_pkg::ST_FIXB: begin
        reducing <= 1'b0;
        pv       <= {1'b0, mod_q};
        pr       <= '0;
        cv       <= a_mag;
        cr       <= b_red;
        solution <= '0;
        status   <= mlcs_pkg::STATUS_NOT_COPRIME;
      end
      mlcs_pkg::ST_UPDATE: begin
        pv       <= cv;
        pr       <= cr;
        cv       <= rem;
        cr       <= right;
        solution <= '0;
        status   <= mlcs_pkg::STATUS_NOT_COPRIME;
      end
      mlcs_pkg::ST_CHECK: begin
        rem      <= pv;
        dvs      <= cv;
        k        <= '0;
        acc      <= '0;
        solution <= cr;
        status   <= mlcs_pkg::STATUS_OK;
      end
      default: begin
      end
    endcase
  end

  `MLCS_ASSERT_SAME(a_no_overlap, clk, rst, s_tready, !m_tvalid, "input and output both open")
  `MLCS_ASSERT_SAME(a_zero_on_fail, clk, rst, m_tvalid && (status != mlcs_pkg::STATUS_OK),
                    solution == '0, "solution not zero on failure status")
  `MLCS_ASSERT_SAME(a_acc_reduced, clk, rst, state == mlcs_pkg::ST_ACC, acc < mod_q,
                    "product accumulator not reduced")
  `MLCS_ASSERT_NEXT(a_bad_mod, clk, rst,
                    s_tvalid && s_tready && (s_tdata[94:64] < 31'd2),
                    m_tvalid && (status == mlcs_pkg::STATUS_BAD_MODULUS),
                    "small modulus not flagged")

endmodule

`default_nettype wire
